[rtl/bcpe_pkg.sv]
// Package for the Bezier curve point evaluation unit.
// Holds the item types, command codes and fixed-point widths.
// No dependencies.
package bcpe_pkg;

    localparam int POINT_W    = 32;
    localparam int T_W        = 16;
    localparam int GUARD_BITS = 8;
    localparam int WORK_W     = POINT_W + GUARD_BITS;

    localparam logic [1:0] CMD_CLEAR    = 2'd0;
    localparam logic [1:0] CMD_APPEND   = 2'd1;
    localparam logic [1:0] CMD_EVALUATE = 2'd2;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [POINT_W-1:0] point_value;
        logic [T_W-1:0]            t_fraction;
    } in_item_t;

    typedef struct packed {
        logic signed [POINT_W-1:0] curve_value;
        logic                      status;
    } out_item_t;

endpackage

[rtl/bcpe_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Used for the control point store and the interpolation work buffer.
// No dependencies.
module bcpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/bezier_curve_point_eval_unit.sv]
// Top level of the Bezier curve point evaluation unit (de Casteljau, one multiplier).
// Depends on bcpe_pkg and bcpe_ram.
//
// Channel    Signals                   Direction  Handshake
// request    start, busy, request      in         accepted when start is high and busy is low
// response   done, response            out        valid for one cycle while done is high
//
// Clear, append and unused commands finish at the accepting edge and leave busy low.
// Evaluate on an empty store gives its item in the cycle after it is accepted, also without busy.
// Evaluate keeps busy high while it copies the points into the work buffer and then runs
// the interpolation steps in turn on the single shared multiplier and work buffer read port.
// Reset is asynchronous and active low and empties the store; the receiver cannot stall.
module bezier_curve_point_eval_unit #(
    parameter int MAX_POINTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  bcpe_pkg::in_item_t request,
    output logic               done,
    output bcpe_pkg::out_item_t response
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int WW = bcpe_pkg::WORK_W;
    localparam int PW = WW + 1 + bcpe_pkg::T_W + 1;
    localparam int SW = 4;

    localparam logic [SW-1:0] ST_IDLE = 4'd0;
    localparam logic [SW-1:0] ST_COPY = 4'd1;
    localparam logic [SW-1:0] ST_RDA  = 4'd2;
    localparam logic [SW-1:0] ST_LDA  = 4'd3;
    localparam logic [SW-1:0] ST_RDB  = 4'd4;
    localparam logic [SW-1:0] ST_LDB  = 4'd5;
    localparam logic [SW-1:0] ST_MUL  = 4'd6;
    localparam logic [SW-1:0] ST_ADD  = 4'd7;
    localparam logic [SW-1:0] ST_RDF  = 4'd8;
    localparam logic [SW-1:0] ST_LDF  = 4'd9;

    logic [SW-1:0] state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] k_reg, k_next;
    logic [IW-1:0] j_reg, j_next;
    logic          done_reg, done_next;

    logic [bcpe_pkg::T_W-1:0] t_reg, t_next;
    logic signed [WW-1:0]     prev_reg, prev_next;
    logic signed [WW-1:0]     b_reg, b_next;
    logic signed [WW:0]       d_reg, d_next;
    logic signed [PW-1:0]     mul_reg, mul_next;
    bcpe_pkg::out_item_t      out_reg, out_next;

    logic                 cp_we;
    logic [IW-1:0]        cp_waddr;
    logic [IW-1:0]        cp_raddr;
    logic [31:0]          cp_rdata;
    logic                 wk_we;
    logic [IW-1:0]        wk_waddr;
    logic [WW-1:0]        wk_wdata;
    logic [IW-1:0]        wk_raddr;
    logic [WW-1:0]        wk_rdata;

    logic                 accept;
    logic signed [WW-1:0] cp_ext;
    logic signed [WW-1:0] wk_val;
    logic signed [PW-1:0] mul_full;
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] delta;
    logic signed [WW-1:0] interp;
    logic signed [WW:0]   fin_sum;
    logic signed [WW:0]   fin_shift;
    logic [IW-1:0]        j_plus1;
    logic [CW-1:0]        i_minus1;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign response = out_reg;

    assign cp_ext   = WW'($signed(cp_rdata)) <<< bcpe_pkg::GUARD_BITS;
    assign wk_val   = $signed(wk_rdata);
    assign mul_full = PW'(d_reg) * PW'($signed({1'b0, t_reg}));
    assign rnd      = mul_reg + PW'(32'sd32768);
    assign delta    = rnd >>> bcpe_pkg::T_W;
    assign interp   = prev_reg + delta[WW-1:0];
    assign fin_sum  = (WW + 1)'(wk_val) + (WW + 1)'(128);
    assign fin_shift = fin_sum >>> bcpe_pkg::GUARD_BITS;
    assign j_plus1  = j_reg + IW'(1);
    assign i_minus1 = i_reg - CW'(1);

    assign cp_we    = accept && (request.command == bcpe_pkg::CMD_APPEND)
                      && (count_reg < CW'(MAX_POINTS));
    assign cp_waddr = count_reg[IW-1:0];
    assign cp_raddr = i_reg[IW-1:0];

    always_comb
    begin
        wk_we    = 1'b0;
        wk_waddr = j_reg;
        wk_wdata = interp;
        wk_raddr = '0;
        if (state_reg == ST_COPY)
        begin
            wk_we    = (i_reg != '0);
            wk_waddr = i_minus1[IW-1:0];
            wk_wdata = cp_ext;
        end
        else if (state_reg == ST_ADD)
        begin
            wk_we = 1'b1;
        end
        if (state_reg == ST_RDB)
        begin
            wk_raddr = j_plus1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        done_next  = 1'b0;
        t_next     = t_reg;
        prev_next  = prev_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        mul_next   = mul_reg;
        out_next   = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.command)
                        bcpe_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        bcpe_pkg::CMD_APPEND:
                        begin
                            if (count_reg < CW'(MAX_POINTS))
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bcpe_pkg::CMD_EVALUATE:
                        begin
                            t_next = request.t_fraction;
                            if (count_reg == '0)
                            begin
                                done_next            = 1'b1;
                                out_next.curve_value = '0;
                                out_next.status      = bcpe_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                i_next     = '0;
                                state_next = ST_COPY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_COPY:
            begin
                if (i_reg == count_reg)
                begin
                    k_next     = count_reg;
                    state_next = (count_reg == CW'(1)) ? ST_RDF : ST_RDA;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                end
            end
            ST_RDA:
            begin
                state_next = ST_LDA;
            end
            ST_LDA:
            begin
                prev_next  = wk_val;
                j_next     = '0;
                state_next = ST_RDB;
            end
            ST_RDB:
            begin
                state_next = ST_LDB;
            end
            ST_LDB:
            begin
                b_next     = wk_val;
                d_next     = (WW + 1)'(wk_val) - (WW + 1)'(prev_reg);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                mul_next   = mul_full;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                prev_next = b_reg;
                if (CW'(j_reg) + CW'(2) < k_reg)
                begin
                    j_next     = j_plus1;
                    state_next = ST_RDB;
                end
                else
                begin
                    k_next     = k_reg - CW'(1);
                    state_next = (k_reg == CW'(2)) ? ST_RDF : ST_RDA;
                end
            end
            ST_RDF:
            begin
                state_next = ST_LDF;
            end
            ST_LDF:
            begin
                done_next       = 1'b1;
                out_next.status = bcpe_pkg::STATUS_OK;
                if (fin_shift > (WW + 1)'(33'sh0_7FFF_FFFF))
                begin
                    out_next.curve_value = 32'sh7FFF_FFFF;
                end
                else if (fin_shift < -(WW + 1)'(33'sh0_8000_0000))
                begin
                    out_next.curve_value = 32'sh8000_0000;
                end
                else
                begin
                    out_next.curve_value = fin_shift[31:0];
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        prev_reg <= prev_next;
        b_reg    <= b_next;
        d_reg    <= d_next;
        mul_reg  <= mul_next;
        out_reg  <= out_next;
    end

    bcpe_ram #(
        .WIDTH (bcpe_pkg::POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .clk   (clk),
        .we    (cp_we),
        .waddr (cp_waddr),
        .wdata (request.point_value),
        .raddr (cp_raddr),
        .rdata (cp_rdata)
    );

    bcpe_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_POINTS)
    ) u_work_ram (
        .clk   (clk),
        .we    (wk_we),
        .waddr (wk_waddr),
        .wdata (wk_wdata),
        .raddr (wk_raddr),
        .rdata (wk_rdata)
    );

endmodule
